[design/scsa_pkg.sv]
// Shared types, constants and codes of the size-class slot allocator.
package scsa_pkg;

    localparam int ADDR_W          = 32;
    localparam int NUM_CLASSES     = 4;
    localparam int PAGES_PER_CLASS = 2;
    localparam int SLOTS_PER_PAGE  = 32;

    // Slots of one class, all pages laid end to end: slot k of the class sits
    // at base + k * slot_bytes, since a page is exactly SLOTS_PER_PAGE slots.
    localparam int REGION_SLOTS = PAGES_PER_CLASS * SLOTS_PER_PAGE;
    localparam int K_W          = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CLASS_W      = 2;
    localparam int SHIFT_W      = 5;
    localparam int STATUS_W     = 2;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [CLASS_W-1:0]  class_t;
    typedef logic [SHIFT_W-1:0]  shift_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [K_W-1:0]      slot_idx_t;

    typedef addr_t [NUM_CLASSES-1:0]                   base_array_t;
    typedef logic [NUM_CLASSES-1:0][REGION_SLOTS-1:0]  busy_array_t;

    localparam addr_t  SLOT_BYTES [NUM_CLASSES] = '{32'd16, 32'd32, 32'd64, 32'd128};
    localparam shift_t SLOT_SHIFT [NUM_CLASSES] = '{5'd4, 5'd5, 5'd6, 5'd7};
    localparam addr_t  BASE_RESET [NUM_CLASSES] = '{32'd4096, 32'd5120, 32'd7168, 32'd11264};

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam status_t ST_DONE        = 2'd0;
    localparam status_t ST_ALLOC_FAIL  = 2'd1;
    localparam status_t ST_REL_REJECT  = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

[design/size_class_slot_allocator.sv]
// Size-class slot allocator: handing out and taking back fixed-size slots.
// A request beat is taken at a rising edge with start high and busy low;
// kind selects allocate (request_size) or release (release_address).
// Four classes of 16, 32, 64 and 128 byte slots each hold two pages of
// 32 slots; an allocation takes the lowest free slot of the smallest class
// that fits, and a release clears the slot of the first class that owns it.
// The request is worked out in the cycle after acceptance, against the
// registered busy bitmaps, and the result beat (granted_address, status)
// stands on the ports for the single cycle in which done is high; done and
// the result are registered at the end of the working cycle. busy is high only
// in the working cycle, so a new request can be taken in the cycle that shows
// the previous result. The receiver cannot stall the result beat; it must
// take it when done is high. The base address of each class is written
// through the APB port at byte addresses 0, 4, 8 and 12; the user must write
// it only while no request is in flight, which the block does not enforce.
// Reset frees every slot, restores the default bases and drops busy and done.
module size_class_slot_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          kind,
    input  logic [scsa_pkg::ADDR_W-1:0]   request_size,
    input  logic [scsa_pkg::ADDR_W-1:0]   release_address,
    output logic                          done,
    output logic [scsa_pkg::ADDR_W-1:0]   granted_address,
    output logic [scsa_pkg::STATUS_W-1:0] status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scsa_pkg::PADDR_W-1:0]  paddr,
    input  logic [scsa_pkg::PDATA_W-1:0]  pwdata,
    output logic [scsa_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import scsa_pkg::*;

    ctrl_cmd_t   cmd;
    base_array_t bases;

    scsa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .bases   (bases)
    );

    scsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    scsa_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .kind            (kind),
        .request_size    (request_size),
        .release_address (release_address),
        .bases           (bases),
        .granted_address (granted_address),
        .status          (status)
    );

`ifndef SYNTHESIS
    // Every result beat directly follows a working cycle.
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a working cycle");

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not enter the working cycle");

    a_fail_no_address: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_DONE)) |-> (granted_address == '0))
        else $error("failed or release result carries an address");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == ST_DONE) || (status == ST_ALLOC_FAIL)
                  || (status == ST_REL_REJECT)))
        else $error("result beat carries an unknown status code");
`endif

endmodule

[design/scsa_regs.sv]
// Configuration registers: the base address of each size class.
module scsa_regs (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [scsa_pkg::PADDR_W-1:0] paddr,
    input  logic [scsa_pkg::PDATA_W-1:0] pwdata,
    output logic [scsa_pkg::PDATA_W-1:0] prdata,
    output logic                    pready,
    output scsa_pkg::base_array_t   bases
);
    import scsa_pkg::*;

    base_array_t base_reg;
    class_t      reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CLASS_W+1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                base_reg[c] <= BASE_RESET[c];
            end
        end
        else if (wr_en)
        begin
            base_reg[reg_idx] <= pwdata[ADDR_W-1:0];
        end
    end

    assign prdata = PDATA_W'(base_reg[reg_idx]);
    assign bases  = base_reg;

endmodule

[design/scsa_ctrl.sv]
// Sequencing controller: accepts a request, runs it in its working state, strobes the result.
module scsa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output scsa_pkg::ctrl_cmd_t  cmd,
    output logic                 busy,
    output logic                 done
);
    import scsa_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic done_reg;

    always_comb
    begin
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.exec;
        end
    end

    assign busy = (state_reg == S_EXEC);
    assign done = done_reg;

endmodule

[design/scsa_datapath.sv]
// Datapath: request capture, busy bitmaps, slot search, release decode and result registers.
module scsa_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  scsa_pkg::ctrl_cmd_t          cmd,
    input  logic                         kind,
    input  logic [scsa_pkg::ADDR_W-1:0]  request_size,
    input  logic [scsa_pkg::ADDR_W-1:0]  release_address,
    input  scsa_pkg::base_array_t        bases,
    output logic [scsa_pkg::ADDR_W-1:0]  granted_address,
    output logic [scsa_pkg::STATUS_W-1:0] status
);
    import scsa_pkg::*;

    logic        kind_reg;
    addr_t       size_reg;
    addr_t       rel_addr_reg;
    busy_array_t busy_reg;
    busy_array_t busy_next;
    addr_t       grant_reg;
    status_t     status_reg;

    class_t      cls;
    logic        cls_ok;
    logic        slot_found;
    slot_idx_t   slot_k;
    addr_t       grant_addr;
    class_t      rel_cls;
    logic        rel_hit;
    slot_idx_t   rel_k;
    addr_t       grant_next;
    status_t     status_next;

    // Allocation: smallest fitting class, then the lowest free slot in it.
    always_comb
    begin
        logic [REGION_SLOTS-1:0] map;
        cls    = '0;
        cls_ok = 1'b0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (size_reg <= SLOT_BYTES[c])
            begin
                cls    = CLASS_W'(c);
                cls_ok = 1'b1;
            end
        end
        map        = busy_reg[cls];
        slot_found = 1'b0;
        slot_k     = '0;
        for (int i = REGION_SLOTS - 1; i >= 0; i--)
        begin
            if (!map[i])
            begin
                slot_found = 1'b1;
                slot_k     = K_W'(i);
            end
        end
        grant_addr = bases[cls] + (ADDR_W'(slot_k) << SLOT_SHIFT[cls]);
    end

    // Release: the first class, in ascending slot size, whose region holds
    // the address at a slot boundary takes it. Offsets wrap modulo 2^32.
    always_comb
    begin
        addr_t off;
        addr_t off_idx;
        rel_cls = '0;
        rel_hit = 1'b0;
        rel_k   = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            off     = rel_addr_reg - bases[c];
            off_idx = off >> SLOT_SHIFT[c];
            if ((off_idx < ADDR_W'(REGION_SLOTS))
                && ((off & (SLOT_BYTES[c] - 32'd1)) == '0))
            begin
                rel_cls = CLASS_W'(c);
                rel_hit = 1'b1;
                rel_k   = off_idx[K_W-1:0];
            end
        end
    end

    always_comb
    begin
        busy_next   = busy_reg;
        grant_next  = '0;
        status_next = ST_DONE;
        if (kind_reg == KIND_ALLOC)
        begin
            if (cls_ok && slot_found)
            begin
                busy_next[cls][slot_k] = 1'b1;
                grant_next             = grant_addr;
            end
            else
            begin
                status_next = ST_ALLOC_FAIL;
            end
        end
        else
        begin
            if (rel_hit)
            begin
                busy_next[rel_cls][rel_k] = 1'b0;
            end
            else
            begin
                status_next = ST_REL_REJECT;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg     <= kind;
            size_reg     <= request_size;
            rel_addr_reg <= release_address;
        end
        if (cmd.exec)
        begin
            grant_reg  <= grant_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else if (cmd.exec)
        begin
            busy_reg <= busy_next;
        end
    end

    assign granted_address = grant_reg;
    assign status          = status_reg;

endmodule
